// File: hdl/fwd_pkg.sv
`default_nettype none
package fwd_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int VALUE_W        = 32;
	localparam int FILL_W         = 5;

	localparam logic [1:0] ACT_ENQ = 2'd0;
	localparam logic [1:0] ACT_DEQ = 2'd1;
	localparam logic [1:0] ACT_DEL = 2'd2;

	// broadcast controls from the top level to every cell
	typedef struct packed {
		logic cmp;
		logic deq;
		logic del;
		logic enq;
	} fwd_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/fifo_with_delete_by_value_top.sv
// Ordered queue of up to DEPTH nonzero words held in a row of cells, front in
// cell 0. Enqueue writes the cell at the fill count, dequeue shifts every cell
// one place towards the front, and delete shifts only the cells from the first
// matching entry backwards. Enqueue and dequeue finish in the idle state;
// delete first registers the compare in every cell, then in S_DEL lets the
// found signal ripple down the row and shift. Each transaction returns one
// result through an output register, and a new transaction is taken in the
// cycle its predecessor's result is taken. Zero values for enqueue or delete,
// enqueue into a full queue, dequeue from an empty one, unused actions and
// unmatched deletes are refused and leave the queue unchanged.
`default_nettype none
module fifo_with_delete_by_value_top #(
	parameter int DEPTH      = fwd_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = fwd_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   action,
	input  wire logic [fwd_pkg::VALUE_W-1:0]  value_in,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              status,
	output logic [fwd_pkg::VALUE_W-1:0]       value_out,
	output logic [fwd_pkg::FILL_W-1:0]        fill_count
);
	import fwd_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_DEL
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic                   out_valid_q;
	logic                   status_q;
	logic [VALUE_W-1:0]     value_out_q;
	logic [FILL_W-1:0]      fill_q;

	logic [DATA_WIDTH-1:0]  val;
	logic                   val_nz;
	logic                   is_full;
	logic                   is_empty;
	logic                   accept;
	logic                   ok_now;
	logic                   go_del;
	logic                   found;
	logic [CNT_W-1:0]       count_nx;
	fwd_ctrl_t              ctrl;

	logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
	logic [DEPTH:0]         found_chain;

	assign val      = DATA_WIDTH'(value_in);
	assign val_nz   = val != '0;
	assign is_full  = count_q == CNT_W'(DEPTH);
	assign is_empty = count_q == '0;
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign found    = found_chain[DEPTH];

	assign found_chain[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] nxt;
		if (i == DEPTH - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_data[i+1];
		end
		fwd_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.CNT_W     (CNT_W),
			.IDX       (i)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.count    (count_q),
			.value    (val),
			.next_data(nxt),
			.found_in (found_chain[i]),
			.found_out(found_chain[i+1]),
			.data     (cell_data[i])
		);
	end

	always_comb begin
		ctrl   = '0;
		ok_now = 1'b0;
		go_del = 1'b0;
		case (action)
			ACT_ENQ: begin
				ok_now   = val_nz && !is_full;
				ctrl.enq = accept && ok_now;
			end
			ACT_DEQ: begin
				ok_now   = !is_empty;
				ctrl.deq = accept && ok_now;
			end
			ACT_DEL: begin
				go_del   = val_nz;
				ctrl.cmp = accept && val_nz;
			end
			default: begin
				ok_now = 1'b0;
			end
		endcase
		ctrl.del = state_q == S_DEL;

		count_nx = count_q;
		if (ctrl.enq) begin
			count_nx = count_q + 1'b1;
		end else if (ctrl.deq || (ctrl.del && found)) begin
			count_nx = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			status_q    <= 1'b0;
			value_out_q <= '0;
			fill_q      <= '0;
		end else begin
			count_q <= count_nx;
			case (state_q)
				S_IDLE: begin
					if (accept && go_del) begin
						state_q     <= S_DEL;
						out_valid_q <= 1'b0;
					end else if (accept) begin
						out_valid_q <= 1'b1;
						status_q    <= !ok_now;
						value_out_q <= ctrl.deq ? VALUE_W'(cell_data[0]) : '0;
						fill_q      <= FILL_W'(count_nx);
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_DEL: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b1;
					status_q    <= !found;
					value_out_q <= '0;
					fill_q      <= FILL_W'(count_nx);
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign value_out  = value_out_q;
	assign fill_count = fill_q;

endmodule
`default_nettype wire

// File: hdl/fwd_cell.sv
`default_nettype none
module fwd_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 5,
	parameter int IDX        = 0
) (
	input  wire logic                  clk,
	input  wire fwd_pkg::fwd_ctrl_t    ctrl,
	input  wire logic [CNT_W-1:0]      count,
	input  wire logic [DATA_WIDTH-1:0] value,
	input  wire logic [DATA_WIDTH-1:0] next_data,
	input  wire logic                  found_in,
	output logic                       found_out,
	output logic [DATA_WIDTH-1:0]      data
);
	import fwd_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic                  match_q;
	logic                  occupied;

	assign occupied  = CNT_W'(IDX) < count;
	assign found_out = found_in | match_q;
	assign data      = data_q;

	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			match_q <= occupied && (data_q == value);
		end
		if (ctrl.deq) begin
			data_q <= next_data;
		end else if (ctrl.del && found_out) begin
			data_q <= next_data;
		end else if (ctrl.enq && (count == CNT_W'(IDX))) begin
			data_q <= value;
		end
	end

endmodule
`default_nettype wire

// File: hdl/fwd_checker.sv
`default_nettype none
module fwd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic [1:0]                  action,
	input wire logic [fwd_pkg::VALUE_W-1:0] value_in,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic                        status,
	input wire logic [fwd_pkg::VALUE_W-1:0] value_out,
	input wire logic [fwd_pkg::FILL_W-1:0]  fill_count
);
	import fwd_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value_out)
			&& $stable(fill_count))
		else $error("result changed while stalled");

	// no new transaction while a result is stalled
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	// refusals never carry a value
	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> value_out == '0)
		else $error("refused transaction returned a value");

	// everything but a delete of a nonzero value answers in the next cycle
	a_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action != ACT_DEL || value_in == '0) |=> out_valid)
		else $error("missing result after single cycle transaction");

endmodule

bind fifo_with_delete_by_value_top fwd_checker u_fwd_checker (.*);
`default_nettype wire
